/* hdl/histogram_peak_contrast_stretch_defines.svh */
// Assertion macros shared by the contrast stretch RTL.
`ifndef HISTOGRAM_PEAK_CONTRAST_STRETCH_DEFINES_SVH
`define HISTOGRAM_PEAK_CONTRAST_STRETCH_DEFINES_SVH
`ifndef SYNTHESIS
`define HPCS_ASSERT_IMPL(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");
`define HPCS_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");
`else
`define HPCS_ASSERT_IMPL(name, ante, cons)
`define HPCS_ASSERT_NEXT(name, ante, cons)
`endif
`endif

/* hdl/hpcs_pkg.sv */
// Shared constants and types of the histogram peak contrast stretch.
package hpcs_pkg;

   localparam int COUNT_WIDTH = 20;
   localparam int PIX_W       = 8;
   localparam int CSR_IDX_W   = 2;

   localparam logic [COUNT_WIDTH-1:0] CNT_MAX  = {COUNT_WIDTH{1'b1}};
   localparam logic [PIX_W-1:0]       LAST_BIN = {PIX_W{1'b1}};

   localparam logic CMD_COUNT = 1'b0;
   localparam logic CMD_MAP   = 1'b1;

   localparam logic KIND_MAP    = 1'b0;
   localparam logic KIND_REPORT = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_LOW_OFFSET  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_OFFSET = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KNEE_LEVEL  = 2'd2;

   localparam logic [PIX_W-1:0] RST_LOW_OFFSET  = 8'd60;
   localparam logic [PIX_W-1:0] RST_HIGH_OFFSET = 8'd10;
   localparam logic [PIX_W-1:0] RST_KNEE_LEVEL  = 8'd250;

   typedef struct packed {
      logic             count;
      logic             last;
      logic [PIX_W-1:0] pixel;
   } hist_cmd_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [PIX_W-1:0] peak;
   } hist_stat_type;

   typedef struct packed {
      logic             en;
      logic [PIX_W-1:0] addr;
      logic [PIX_W-1:0] data;
   } lut_wr_type;

endpackage

/* hdl/hpcs_hist.sv */
// Histogram memory: saturating bin count, peak scan with clear, clearing pass after reset.
`include "histogram_peak_contrast_stretch_defines.svh"
module hpcs_hist (
   input  logic                  clock,
   input  logic                  reset,
   input  hpcs_pkg::hist_cmd_type cmd,
   output hpcs_pkg::hist_stat_type stat
);

   logic [hpcs_pkg::COUNT_WIDTH-1:0] hist_mem [256];
   logic [hpcs_pkg::COUNT_WIDTH-1:0] rd_data_ff;

   logic                             cnt_pend_ff;
   logic                             cnt_last_ff;
   logic [hpcs_pkg::PIX_W-1:0]       cnt_addr_ff;
   logic                             fwd_ff;
   logic [hpcs_pkg::COUNT_WIDTH-1:0] fwd_data_ff;

   logic                             scan_act_ff;
   logic                             scan_rpt_ff;
   logic [hpcs_pkg::PIX_W-1:0]       scan_ff;
   logic                             cmp_vld_ff;
   logic [hpcs_pkg::PIX_W-1:0]       cmp_addr_ff;
   logic [hpcs_pkg::COUNT_WIDTH-1:0] best_ff;
   logic [hpcs_pkg::PIX_W-1:0]       peak_ff;
   logic                             done_ff;

   logic [hpcs_pkg::COUNT_WIDTH-1:0] cur;
   logic [hpcs_pkg::COUNT_WIDTH-1:0] inc_val;
   logic                             wr_en;
   logic [hpcs_pkg::PIX_W-1:0]       wr_addr;
   logic [hpcs_pkg::COUNT_WIDTH-1:0] wr_data;
   logic [hpcs_pkg::PIX_W-1:0]       rd_addr;

   always_comb begin
      cur     = fwd_ff ? fwd_data_ff : rd_data_ff;
      inc_val = (cur == hpcs_pkg::CNT_MAX) ? cur : cur + hpcs_pkg::COUNT_WIDTH'(1);
      wr_en   = cnt_pend_ff | cmp_vld_ff;
      wr_addr = cmp_vld_ff ? cmp_addr_ff : cnt_addr_ff;
      wr_data = cmp_vld_ff ? '0 : inc_val;
      rd_addr = scan_act_ff ? scan_ff : cmd.pixel;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         hist_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= hist_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_pend_ff <= 1'b0;
         cnt_last_ff <= 1'b0;
         fwd_ff      <= 1'b0;
         scan_act_ff <= 1'b1;
         scan_rpt_ff <= 1'b0;
         scan_ff     <= '0;
         cmp_vld_ff  <= 1'b0;
         done_ff     <= 1'b0;
         best_ff     <= '0;
         peak_ff     <= '0;
      end else begin
         cnt_pend_ff <= cmd.count;
         cnt_last_ff <= cmd.count & cmd.last;
         fwd_ff      <= cmd.count & cnt_pend_ff & (cmd.pixel == cnt_addr_ff);
         cmp_vld_ff  <= scan_act_ff;
         done_ff     <= cmp_vld_ff & (cmp_addr_ff == hpcs_pkg::LAST_BIN) & scan_rpt_ff;
         if (cnt_pend_ff && cnt_last_ff) begin
            scan_act_ff <= 1'b1;
            scan_rpt_ff <= 1'b1;
            scan_ff     <= '0;
            best_ff     <= '0;
            peak_ff     <= '0;
         end else if (scan_act_ff) begin
            scan_ff <= scan_ff + hpcs_pkg::PIX_W'(1);
            if (scan_ff == hpcs_pkg::LAST_BIN) begin
               scan_act_ff <= 1'b0;
            end
         end
         if (cmp_vld_ff && (rd_data_ff > best_ff)) begin
            best_ff <= rd_data_ff;
            peak_ff <= cmp_addr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_addr_ff <= cmd.pixel;
      fwd_data_ff <= inc_val;
      cmp_addr_ff <= scan_ff;
   end

   assign stat.busy = scan_act_ff | cmp_vld_ff | (cnt_pend_ff & cnt_last_ff);
   assign stat.done = done_ff;
   assign stat.peak = peak_ff;

   `HPCS_ASSERT_IMPL(a_count_not_in_scan, cnt_pend_ff, !cmp_vld_ff)
   `HPCS_ASSERT_NEXT(a_last_starts_scan, cnt_pend_ff && cnt_last_ff, scan_act_ff && scan_ff == '0)

endmodule

/* hdl/hpcs_lut.sv */
// Level table memory: identity fill after reset, build writes, registered lookup.
module hpcs_lut (
   input  logic                       clock,
   input  logic                       reset,
   input  hpcs_pkg::lut_wr_type       wr,
   input  logic [hpcs_pkg::PIX_W-1:0] rd_addr,
   output logic [hpcs_pkg::PIX_W-1:0] rd_data,
   output logic                       busy
);

   logic [hpcs_pkg::PIX_W-1:0] lut_mem [256];
   logic [hpcs_pkg::PIX_W-1:0] rd_data_ff;
   logic                       fill_act_ff;
   logic [hpcs_pkg::PIX_W-1:0] fill_ff;

   logic                       wr_en;
   logic [hpcs_pkg::PIX_W-1:0] wr_addr;
   logic [hpcs_pkg::PIX_W-1:0] wr_data;

   always_comb begin
      wr_en   = fill_act_ff | wr.en;
      wr_addr = fill_act_ff ? fill_ff : wr.addr;
      wr_data = fill_act_ff ? fill_ff : wr.data;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         lut_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= lut_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_act_ff <= 1'b1;
         fill_ff     <= '0;
      end else if (fill_act_ff) begin
         fill_ff <= fill_ff + hpcs_pkg::PIX_W'(1);
         if (fill_ff == hpcs_pkg::LAST_BIN) begin
            fill_act_ff <= 1'b0;
         end
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = fill_act_ff;

endmodule

/* hdl/hpcs_build.sv */
// Table builder: knee points, per-segment slope division, incremental segment drawing.
`include "histogram_peak_contrast_stretch_defines.svh"
module hpcs_build (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [hpcs_pkg::PIX_W-1:0] peak,
   input  logic [hpcs_pkg::PIX_W-1:0] low_offset,
   input  logic [hpcs_pkg::PIX_W-1:0] high_offset,
   input  logic [hpcs_pkg::PIX_W-1:0] knee_level,
   output hpcs_pkg::lut_wr_type       wr,
   output logic                       done
);

   typedef enum logic [4:0] {
      B_IDLE  = 5'b00001,
      B_SETUP = 5'b00010,
      B_DIV   = 5'b00100,
      B_RUN   = 5'b01000,
      B_LAST  = 5'b10000
   } build_state_type;

   localparam logic [1:0] SEG_LOW  = 2'd0;
   localparam logic [1:0] SEG_MID  = 2'd1;
   localparam logic [1:0] SEG_HIGH = 2'd2;

   build_state_type            state_ff;
   logic [1:0]                 seg_ff;
   logic [hpcs_pkg::PIX_W-1:0] a_ff, b_ff, k_ff;
   logic [hpcs_pkg::PIX_W-1:0] x0_ff, x1_ff, den_ff, base_ff;
   logic                       inc_ff;
   logic [hpcs_pkg::PIX_W-1:0] div_n_ff, div_r_ff;
   logic [2:0]                 div_cnt_ff;
   logic [hpcs_pkg::PIX_W-1:0] q_ff, r_ff, t_ff;
   logic                       done_ff;

   logic [hpcs_pkg::PIX_W-1:0] x0, y0, x1, y1, den, dy, base;
   logic                       inc;
   logic [hpcs_pkg::PIX_W:0]   b_sum;
   logic [hpcs_pkg::PIX_W:0]   r_sh, r_sum;
   logic                       ge, cy;

   always_comb begin
      case (seg_ff)
         SEG_LOW: begin
            x0 = '0;
            y0 = '0;
            x1 = a_ff;
            y1 = a_ff;
         end
         SEG_MID: begin
            x0 = a_ff;
            y0 = a_ff;
            x1 = b_ff;
            y1 = k_ff;
         end
         default: begin
            x0 = b_ff;
            y0 = k_ff;
            x1 = hpcs_pkg::LAST_BIN;
            y1 = hpcs_pkg::LAST_BIN;
         end
      endcase
      den   = x1 - x0;
      inc   = (y1 >= y0);
      dy    = inc ? (y1 - y0) : (y0 - y1);
      base  = inc ? y0 : y1;
      b_sum = {1'b0, peak} + {1'b0, high_offset};
      r_sh  = {div_r_ff, div_n_ff[hpcs_pkg::PIX_W-1]};
      ge    = (r_sh >= {1'b0, den_ff});
      r_sum = {1'b0, r_ff} + {1'b0, div_r_ff};
      cy    = (r_sum >= {1'b0, den_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            B_IDLE: begin
               if (start) begin
                  state_ff <= B_SETUP;
               end
            end
            B_SETUP: begin
               if (den != '0) begin
                  state_ff <= B_DIV;
               end else if (seg_ff == SEG_HIGH) begin
                  state_ff <= B_LAST;
               end
            end
            B_DIV: begin
               if (div_cnt_ff == 3'd7) begin
                  state_ff <= B_RUN;
               end
            end
            B_RUN: begin
               if (t_ff == den_ff) begin
                  state_ff <= (seg_ff == SEG_HIGH) ? B_LAST : B_SETUP;
               end
            end
            B_LAST: begin
               done_ff  <= 1'b1;
               state_ff <= B_IDLE;
            end
            default: begin
               state_ff <= B_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         B_IDLE: begin
            seg_ff <= SEG_LOW;
            a_ff   <= (peak >= low_offset) ? (peak - low_offset) : '0;
            b_ff   <= b_sum[hpcs_pkg::PIX_W] ? hpcs_pkg::LAST_BIN : b_sum[hpcs_pkg::PIX_W-1:0];
            k_ff   <= knee_level;
         end
         B_SETUP: begin
            x0_ff      <= x0;
            x1_ff      <= x1;
            den_ff     <= den;
            inc_ff     <= inc;
            base_ff    <= base;
            div_n_ff   <= dy;
            div_r_ff   <= '0;
            div_cnt_ff <= '0;
            if (den == '0) begin
               seg_ff <= seg_ff + 2'd1;
            end
         end
         B_DIV: begin
            div_r_ff   <= ge ? hpcs_pkg::PIX_W'(r_sh - {1'b0, den_ff})
                             : r_sh[hpcs_pkg::PIX_W-1:0];
            div_n_ff   <= {div_n_ff[hpcs_pkg::PIX_W-2:0], ge};
            div_cnt_ff <= div_cnt_ff + 3'd1;
            q_ff       <= '0;
            r_ff       <= '0;
            t_ff       <= '0;
         end
         B_RUN: begin
            r_ff <= cy ? hpcs_pkg::PIX_W'(r_sum - {1'b0, den_ff}) : r_sum[hpcs_pkg::PIX_W-1:0];
            q_ff <= q_ff + div_n_ff + hpcs_pkg::PIX_W'(cy);
            t_ff <= t_ff + hpcs_pkg::PIX_W'(1);
            if (t_ff == den_ff) begin
               seg_ff <= seg_ff + 2'd1;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      wr.en   = 1'b0;
      wr.addr = inc_ff ? (x0_ff + t_ff) : (x1_ff - t_ff);
      wr.data = q_ff + base_ff;
      if (state_ff == B_RUN) begin
         wr.en = inc_ff ? (t_ff != den_ff) : (t_ff != '0);
      end else if (state_ff == B_LAST) begin
         wr.en   = 1'b1;
         wr.addr = hpcs_pkg::LAST_BIN;
         wr.data = hpcs_pkg::LAST_BIN;
      end
   end

   assign done = done_ff;

   `HPCS_ASSERT_IMPL(a_run_remainder, state_ff == B_RUN, r_ff < den_ff && t_ff <= den_ff)

endmodule

/* hdl/histogram_peak_contrast_stretch.sv */
// Top level of the histogram peak contrast stretch: stream ports, registers, sequencing.
// Count items (tuser 0) are taken one per cycle back to back while in the run state: the
// histogram memory read-modify-write is pipelined with forwarding between back-to-back count
// items on the same bin. A map item (tuser 1) is read through the registered read port of the
// level table memory, then waits in the map state until the result register is free on
// rsp_tready; no new item is taken before that. A count item with tlast runs the saturating
// count write, a peak scan over all 256 bins that also clears every bin, then the table build,
// which skips each empty segment and divides, then draws, each other segment, before its
// report is offered. After reset both memories run a clearing pass over all 256 entries
// (histogram to zero, table to identity) during which no item is accepted; register writes on
// the csr channel are always taken and should only be issued while no item is in flight.
`include "histogram_peak_contrast_stretch_defines.svh"
module histogram_peak_contrast_stretch (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] pixel
   input  logic [0:0]  req_tuser,   // [0] cmd
   input  logic        req_tlast,   // frame_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] mapped_pixel, [15:8] peak_bin
   output logic [0:0]  rsp_tuser,   // [0] kind
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data
);

   typedef enum logic [5:0] {
      ST_INIT   = 6'b000001,
      ST_RUN    = 6'b000010,
      ST_MAP    = 6'b000100,
      ST_SCAN   = 6'b001000,
      ST_BUILD  = 6'b010000,
      ST_REPORT = 6'b100000
   } top_state_type;

   top_state_type              state_ff, state_in;
   logic [hpcs_pkg::PIX_W-1:0] low_off_ff, high_off_ff, knee_ff;
   logic [hpcs_pkg::PIX_W-1:0] last_peak_ff;
   logic [hpcs_pkg::PIX_W-1:0] pix_ff;
   logic                       rsp_vld_ff, rsp_vld_in;
   logic                       rsp_kind_ff;
   logic [hpcs_pkg::PIX_W-1:0] rsp_pix_ff;
   logic [hpcs_pkg::PIX_W-1:0] rsp_peak_ff;

   hpcs_pkg::hist_cmd_type     hist_cmd;
   hpcs_pkg::hist_stat_type    hist_stat;
   hpcs_pkg::lut_wr_type       lut_wr;
   logic [hpcs_pkg::PIX_W-1:0] lut_rd_addr;
   logic [hpcs_pkg::PIX_W-1:0] lut_rd_data;
   logic                       lut_busy;
   logic                       build_start;
   logic                       build_done;

   logic                       req_xfer;
   logic                       out_free;
   logic                       load_map;
   logic                       load_rpt;

   hpcs_hist u_hist (
      .clock (clock),
      .reset (reset),
      .cmd   (hist_cmd),
      .stat  (hist_stat)
   );

   hpcs_lut u_lut (
      .clock   (clock),
      .reset   (reset),
      .wr      (lut_wr),
      .rd_addr (lut_rd_addr),
      .rd_data (lut_rd_data),
      .busy    (lut_busy)
   );

   hpcs_build u_build (
      .clock       (clock),
      .reset       (reset),
      .start       (build_start),
      .peak        (hist_stat.peak),
      .low_offset  (low_off_ff),
      .high_offset (high_off_ff),
      .knee_level  (knee_ff),
      .wr          (lut_wr),
      .done        (build_done)
   );

   always_comb begin
      req_tready     = (state_ff == ST_RUN);
      req_xfer       = req_tvalid & req_tready;
      hist_cmd.count = req_xfer & (req_tuser[0] == hpcs_pkg::CMD_COUNT);
      hist_cmd.last  = req_tlast;
      hist_cmd.pixel = req_tdata[7:0];
      lut_rd_addr    = (state_ff == ST_RUN) ? req_tdata[7:0] : pix_ff;
      build_start    = (state_ff == ST_SCAN) & hist_stat.done;
      out_free       = ~rsp_vld_ff | rsp_tready;
      load_map       = (state_ff == ST_MAP) & out_free;
      load_rpt       = (state_ff == ST_REPORT) & out_free;
      rsp_vld_in     = (load_map | load_rpt) ? 1'b1 : (rsp_vld_ff & ~rsp_tready);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: begin
            if (!hist_stat.busy && !lut_busy) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (req_xfer) begin
               if (req_tuser[0] == hpcs_pkg::CMD_MAP) begin
                  state_in = ST_MAP;
               end else if (req_tlast) begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_MAP: begin
            if (out_free) begin
               state_in = ST_RUN;
            end
         end
         ST_SCAN: begin
            if (hist_stat.done) begin
               state_in = ST_BUILD;
            end
         end
         ST_BUILD: begin
            if (build_done) begin
               state_in = ST_REPORT;
            end
         end
         ST_REPORT: begin
            if (out_free) begin
               state_in = ST_RUN;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         rsp_vld_ff   <= 1'b0;
         last_peak_ff <= '0;
         low_off_ff   <= hpcs_pkg::RST_LOW_OFFSET;
         high_off_ff  <= hpcs_pkg::RST_HIGH_OFFSET;
         knee_ff      <= hpcs_pkg::RST_KNEE_LEVEL;
      end else begin
         state_ff   <= state_in;
         rsp_vld_ff <= rsp_vld_in;
         if (build_start) begin
            last_peak_ff <= hist_stat.peak;
         end
         if (csr_valid) begin
            case (csr_index)
               hpcs_pkg::CSR_LOW_OFFSET:  low_off_ff  <= csr_data;
               hpcs_pkg::CSR_HIGH_OFFSET: high_off_ff <= csr_data;
               hpcs_pkg::CSR_KNEE_LEVEL:  knee_ff     <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         pix_ff <= req_tdata[7:0];
      end
      if (load_map) begin
         rsp_kind_ff <= hpcs_pkg::KIND_MAP;
         rsp_pix_ff  <= lut_rd_data;
         rsp_peak_ff <= last_peak_ff;
      end else if (load_rpt) begin
         rsp_kind_ff <= hpcs_pkg::KIND_REPORT;
         rsp_pix_ff  <= '0;
         rsp_peak_ff <= last_peak_ff;
      end
   end

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {rsp_peak_ff, rsp_pix_ff};
   assign rsp_tuser  = rsp_kind_ff;

   `HPCS_ASSERT_IMPL(a_accept_memories_free, req_xfer, !hist_stat.busy && !lut_busy)
   `HPCS_ASSERT_IMPL(a_build_after_scan, state_ff == ST_BUILD, !hist_stat.busy)

endmodule
